FILE: design/tlig_pkg.sv
package tlig_pkg;

  // Field and register widths
  localparam int unsigned IdxW   = 20;
  localparam int unsigned CoordW = 10;
  localparam int unsigned LodW   = 2;
  localparam int unsigned TileW  = 11;

  localparam logic [TileW-1:0] TileReset = 11'd128;

  // Pass selector codes
  localparam logic PassInterior = 1'b0;
  localparam logic PassStitch   = 1'b1;

  // What a queued point turns into
  typedef enum logic [2:0] {
    KIND_CELL_EVEN,
    KIND_CELL_ODD,
    KIND_TOP,
    KIND_BOTTOM,
    KIND_LEFT,
    KIND_RIGHT
  } kind_e;

  typedef struct packed {
    logic              func;
    logic [LodW-1:0]   lod;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] index_a;
    logic [IdxW-1:0] index_b;
    logic [IdxW-1:0] index_c;
    logic            last_face;
  } out_t;

  // Classified point with its precomputed products
  typedef struct packed {
    kind_e             kind;
    logic              pair;      // two triangles rather than one
    logic [LodW-1:0]   lod;
    logic [CoordW-1:0] col;
    logic [IdxW-1:0]   row_base;  // row * tile_size
    logic [IdxW-1:0]   mid_base;  // rounded row * tile_size (side stitching)
    logic [IdxW-1:0]   step;      // tile_size * cell size
    logic [TileW-1:0]  col_mid;   // column rounded to nearest cell corner
    logic [CoordW-1:0] col_down;  // column rounded down to cell corner
  } job_t;

endpackage

FILE: design/tlig_front.sv
module tlig_front #(
  parameter int MaxLod = 3
) (
  input  tlig_pkg::in_t                   in_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tlig_pkg::TileW-1:0]      tile_i,
  input  logic                            full_i,
  output logic                            push_o,
  output tlig_pkg::job_t                  job_o
);

  localparam int unsigned CW = 13;  // signed compare width

  logic [3:0]                     cell_s;
  logic [tlig_pkg::CoordW-1:0]    smask;
  logic [tlig_pkg::TileW-1:0]     smask_w;
  logic [tlig_pkg::TileW-1:0]     half;
  logic [tlig_pkg::TileW-1:0]     col_h;
  logic [tlig_pkg::TileW-1:0]     row_h;
  logic [tlig_pkg::TileW-1:0]     row_mid;
  logic [2*tlig_pkg::TileW-1:0]   mid_prod;
  logic [tlig_pkg::CoordW+tlig_pkg::TileW-1:0] row_prod;
  logic [tlig_pkg::TileW+3-1:0]   step_w;
  logic signed [CW-1:0]           t_s, i_s, j_s, s_s, tm1, lo, hi, side_hi;
  logic                           lod_ok, cell_ok, stitch_ok;
  logic                           is_top, is_bot, side_rows, is_left, is_right;
  logic                           col_pair, row_pair, any;
  tlig_pkg::kind_e                kind;
  logic                           pair;

  // Cell size and rounding masks
  assign cell_s  = 4'd1 << in_data_i.lod;
  assign smask   = tlig_pkg::CoordW'(cell_s) - 1'b1;
  assign smask_w = tlig_pkg::TileW'(cell_s) - 1'b1;
  assign half    = tlig_pkg::TileW'(cell_s >> 1);
  assign col_h   = {1'b0, in_data_i.col} + half;
  assign row_h   = {1'b0, in_data_i.row} + half;
  assign row_mid = row_h & ~smask_w;

  // Products handed on to the back end
  assign row_prod = in_data_i.row * tile_i;
  assign mid_prod = row_mid * tile_i;
  assign step_w   = {3'b000, tile_i} << in_data_i.lod;

  // Range checks on signed values so that tiny tiles behave
  assign t_s     = $signed({2'b00, tile_i});
  assign i_s     = $signed({3'b000, in_data_i.col});
  assign j_s     = $signed({3'b000, in_data_i.row});
  assign s_s     = $signed({9'd0, cell_s});
  assign tm1     = t_s - 13'sd1;
  assign lo      = (in_data_i.lod == '0) ? 13'sd0 : s_s;
  assign hi      = (in_data_i.lod == '0) ? tm1 : t_s - (s_s <<< 1);
  assign side_hi = t_s - s_s - 13'sd1;

  assign lod_ok    = (int'(in_data_i.lod) <= MaxLod);
  assign cell_ok   = lod_ok && (in_data_i.func == tlig_pkg::PassInterior)
                     && (i_s >= lo) && (i_s < hi) && (j_s >= lo) && (j_s < hi)
                     && ((in_data_i.col & smask) == '0)
                     && ((in_data_i.row & smask) == '0);
  assign stitch_ok = lod_ok && (in_data_i.func == tlig_pkg::PassStitch)
                     && (in_data_i.lod != '0);

  assign is_top    = (in_data_i.row == '0) && (i_s < tm1);
  assign is_bot    = (j_s == tm1) && (i_s < tm1);
  assign side_rows = (j_s > s_s - 13'sd1) && (j_s < side_hi);
  assign is_left   = (in_data_i.col == '0) && side_rows;
  assign is_right  = (i_s == tm1) && side_rows;

  assign col_pair = ((col_h & smask_w) == '0);
  assign row_pair = ((row_h & smask_w) == '0);

  // Classification; the stitching sides cannot overlap, order follows emission
  always_comb begin
    any  = 1'b1;
    kind = tlig_pkg::KIND_CELL_EVEN;
    pair = 1'b1;
    priority if (cell_ok) begin
      kind = in_data_i.col[0] ? tlig_pkg::KIND_CELL_ODD : tlig_pkg::KIND_CELL_EVEN;
    end else if (stitch_ok && is_top) begin
      kind = tlig_pkg::KIND_TOP;
      pair = col_pair;
    end else if (stitch_ok && is_bot) begin
      kind = tlig_pkg::KIND_BOTTOM;
      pair = col_pair;
    end else if (stitch_ok && is_left) begin
      kind = tlig_pkg::KIND_LEFT;
      pair = row_pair;
    end else if (stitch_ok && is_right) begin
      kind = tlig_pkg::KIND_RIGHT;
      pair = row_pair;
    end else begin
      any = 1'b0;
    end
  end

  assign job_o.kind     = kind;
  assign job_o.pair     = pair;
  assign job_o.lod      = in_data_i.lod;
  assign job_o.col      = in_data_i.col;
  assign job_o.row_base = row_prod[tlig_pkg::IdxW-1:0];
  assign job_o.mid_base = mid_prod[tlig_pkg::IdxW-1:0];
  assign job_o.step     = tlig_pkg::IdxW'(step_w);
  assign job_o.col_mid  = col_h & ~smask_w;
  assign job_o.col_down = in_data_i.col & ~smask;

  // Points that give no triangle are dropped here
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && any;

endmodule

FILE: design/tlig_queue.sv
module tlig_queue #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlig_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tlig_pkg::job_t data_o,
  output logic           empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tlig_pkg::job_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/tlig_back.sv
module tlig_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlig_pkg::job_t             job_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  logic [tlig_pkg::TileW-1:0] tile_i,
  output tlig_pkg::out_t             out_data_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i
);

  localparam int unsigned W = tlig_pkg::IdxW;

  logic           tri_q, tri_d;
  logic           out_valid_q, out_valid_d;
  tlig_pkg::out_t out_data_q, out_data_d;
  logic           emit, last;
  logic [W-1:0]   ci, sv, tw, jt, mt, st, mi, qi;
  logic [W-1:0]   p00, p01, p10, p11, bj, bm, qs;
  logic [W-1:0]   ia, ib, ic;

  // Operands, all arithmetic wraps at the index width
  assign ci  = W'(job_i.col);
  assign sv  = W'(4'd1 << job_i.lod);
  assign tw  = W'(tile_i);
  assign jt  = job_i.row_base;
  assign mt  = job_i.mid_base;
  assign st  = job_i.step;
  assign mi  = W'(job_i.col_mid);
  assign qi  = W'(job_i.col_down);
  assign p00 = ci + jt;
  assign p01 = p00 + st;
  assign p10 = p00 + sv;
  assign p11 = p01 + sv;
  assign bj  = jt - st;
  assign bm  = mt - st;
  assign qs  = qi + st;

  // Triangle for the current face of the head point
  always_comb begin
    ia = '0;
    ib = '0;
    ic = '0;
    unique case (job_i.kind)
      tlig_pkg::KIND_CELL_EVEN: begin
        if (!tri_q) begin
          ia = p00; ib = p01; ic = p10;
        end else begin
          ia = p10; ib = p01; ic = p11;
        end
      end
      tlig_pkg::KIND_CELL_ODD: begin
        if (!tri_q) begin
          ia = p00; ib = p11; ic = p10;
        end else begin
          ia = p00; ib = p01; ic = p11;
        end
      end
      tlig_pkg::KIND_TOP: begin
        if (!tri_q) begin
          ia = ci; ib = mi + st; ic = ci + 1'b1;
        end else begin
          ia = ci; ib = qs; ic = qs + sv;
        end
      end
      tlig_pkg::KIND_BOTTOM: begin
        if (!tri_q) begin
          ia = p00 + 1'b1; ib = mi + bj; ic = p00;
        end else begin
          ia = p00; ib = qi + bj + sv; ic = qi + bj;
        end
      end
      tlig_pkg::KIND_LEFT: begin
        if (!tri_q) begin
          ia = jt; ib = jt + tw; ic = mt + sv;
        end else begin
          ia = jt; ib = mt + sv; ic = bm + sv;
        end
      end
      tlig_pkg::KIND_RIGHT: begin
        if (!tri_q) begin
          ia = p00; ib = mt + ci - sv; ic = p00 + tw;
        end else begin
          ia = p00; ib = bm + ci - sv; ic = mt + ci - sv;
        end
      end
      default: begin
        ia = '0;
      end
    endcase
  end

  // One face per cycle into the output register while the queue holds a point and the output is not stalled
  assign emit  = !empty_i && (!out_valid_q || out_ready_i);
  assign last  = !job_i.pair || tri_q;
  assign pop_o = emit && last;

  always_comb begin
    tri_d       = tri_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d          = 1'b1;
      out_data_d.index_a   = ia;
      out_data_d.index_b   = ib;
      out_data_d.index_c   = ic;
      out_data_d.last_face = last;
      tri_d                = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tri_q       <= tri_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/terrain_lod_index_generator_unit.sv
// Terrain LOD index generator. Each transfer on the input carries one grid point, a level
// of detail and a pass (interior cells or border stitching); the block returns the
// triangles that point adds to the level's index list, one triangle per output transfer,
// with last_face marking the final one of the point. The front end classifies a point
// and forms the row times tile_size products combinationally as it enters the queue;
// the back end then gives one triangle per cycle while the output is not stalled, and
// points giving no triangle take none of the output's time. A small queue between the
// two ends lets the input keep flowing while the output stalls. tile_size resets to 128;
// the user writes it through cfg_we_i only while the block is idle; nothing enforces this.
module terrain_lod_index_generator_unit #(
  parameter int MAX_LOD     = 3,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tlig_pkg::TileW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tlig_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tlig_pkg::out_t             out_data_o
);

  logic [tlig_pkg::TileW-1:0] tile_q;
  logic                       push, full, pop, empty;
  tlig_pkg::job_t             job_in, job_head;

  // Tile size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= tlig_pkg::TileReset;
    end else if (cfg_we_i) begin
      tile_q <= cfg_wdata_i;
    end
  end

  tlig_front #(
    .MaxLod (MAX_LOD)
  ) u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .tile_i     (tile_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  tlig_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_head),
    .empty_o (empty)
  );

  tlig_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .tile_i      (tile_q),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
